[sv/xmlesc_pkg.sv]
`default_nettype none

package xmlesc_pkg;

  // longest escape run (&quot;) and the width of a position inside it
  localparam int unsigned MAX_RUN = 6;
  localparam int unsigned IDX_W   = $clog2(MAX_RUN);

  // register file
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned MODE_W  = 2;
  localparam logic [PADDR_W-3:0] REG_NORM_MODE = 1'b0;

  // normalization modes
  localparam logic [MODE_W-1:0] MODE_ATTR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PI      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd3;

  // characters that drive the escape decision
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  // characters that only appear inside escapes
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_Q    = 8'h71;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_O    = 8'h6F;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UD   = 8'h44;

  typedef enum logic [2:0] {
    ESC_NONE,
    ESC_LT,
    ESC_GT,
    ESC_AMP,
    ESC_QUOT,
    ESC_TAB,
    ESC_LF,
    ESC_CR
  } esc_kind_e;

  // one classified input byte, handed from the classifier to the run stage
  typedef struct packed {
    esc_kind_e  kind;
    logic [7:0] raw;
  } run_item_t;

  // position of the final byte of a run
  function automatic logic [IDX_W-1:0] esc_last_idx(input esc_kind_e kind);
    logic [IDX_W-1:0] r;
    case (kind)
      ESC_NONE: r = IDX_W'(0);
      ESC_LT:   r = IDX_W'(3);
      ESC_GT:   r = IDX_W'(3);
      ESC_QUOT: r = IDX_W'(5);
      default:  r = IDX_W'(4);
    endcase
    return r;
  endfunction

  // byte at one position of a run
  function automatic logic [7:0] esc_byte(input esc_kind_e kind,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [7:0] raw);
    logic [7:0] tail;
    logic [7:0] r;
    // bytes after the leading ampersand of each escape
    tail = CH_SEMI;
    case (kind)
      ESC_LT: begin
        case (idx)
          IDX_W'(1): tail = CH_L;
          IDX_W'(2): tail = CH_T;
          default:   tail = CH_SEMI;
        endcase
      end
      ESC_GT: begin
        case (idx)
          IDX_W'(1): tail = CH_G;
          IDX_W'(2): tail = CH_T;
          default:   tail = CH_SEMI;
        endcase
      end
      ESC_AMP: begin
        case (idx)
          IDX_W'(1): tail = CH_A;
          IDX_W'(2): tail = CH_M;
          IDX_W'(3): tail = CH_P;
          default:   tail = CH_SEMI;
        endcase
      end
      ESC_QUOT: begin
        case (idx)
          IDX_W'(1): tail = CH_Q;
          IDX_W'(2): tail = CH_U;
          IDX_W'(3): tail = CH_O;
          IDX_W'(4): tail = CH_T;
          default:   tail = CH_SEMI;
        endcase
      end
      ESC_TAB, ESC_LF, ESC_CR: begin
        case (idx)
          IDX_W'(1): tail = CH_HASH;
          IDX_W'(2): tail = CH_X;
          IDX_W'(3): tail = (kind == ESC_TAB) ? CH_9 :
                            (kind == ESC_LF)  ? CH_UA : CH_UD;
          default:   tail = CH_SEMI;
        endcase
      end
      default: tail = CH_SEMI;
    endcase
    if (kind == ESC_NONE) begin
      r = raw;
    end else if (idx == IDX_W'(0)) begin
      r = CH_AMP;
    end else begin
      r = tail;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/xmlesc_regs.sv]
`default_nettype none

module xmlesc_regs
  import xmlesc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [MODE_W-1:0]  norm_mode_o
);

  logic [MODE_W-1:0] norm_mode_q;
  logic              hit;
  logic              wr_en;

  // word decode, byte offset ignored
  assign hit   = (paddr[PADDR_W-1:2] == REG_NORM_MODE);
  assign wr_en = psel && penable && pwrite && hit;

  // mode register, low bits of the write data kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_mode_q <= MODE_ATTR;
    end else if (wr_en) begin
      norm_mode_q <= pwdata[MODE_W-1:0];
    end
  end

  // read back, zero outside the register
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(PDATA_W-MODE_W){1'b0}}, norm_mode_q};
    end
  end

  assign pready      = 1'b1;
  assign norm_mode_o = norm_mode_q;

endmodule

`default_nettype wire

[sv/xmlesc_classify.sv]
`default_nettype none

module xmlesc_classify
  import xmlesc_pkg::*;
(
  input  wire logic [7:0]        byte_i,
  input  wire logic [MODE_W-1:0] norm_mode_i,
  output run_item_t              item_o
);

  logic attr;
  logic text;

  assign attr = (norm_mode_i == MODE_ATTR);
  assign text = (norm_mode_i == MODE_TEXT);

  // pick the escape for this byte in the current mode
  always_comb begin
    item_o.raw  = byte_i;
    item_o.kind = ESC_NONE;
    if (byte_i == CH_LT && (attr || text)) begin
      item_o.kind = ESC_LT;
    end else if (byte_i == CH_GT && text) begin
      item_o.kind = ESC_GT;
    end else if (byte_i == CH_AMP && (attr || text)) begin
      item_o.kind = ESC_AMP;
    end else if (byte_i == CH_QUOT && attr) begin
      item_o.kind = ESC_QUOT;
    end else if (byte_i == CH_TAB && attr) begin
      item_o.kind = ESC_TAB;
    end else if (byte_i == CH_LF && attr) begin
      item_o.kind = ESC_LF;
    end else if (byte_i == CH_CR) begin
      item_o.kind = ESC_CR;
    end
  end

endmodule

`default_nettype wire

[sv/xmlesc_emit.sv]
`default_nettype none

module xmlesc_emit
  import xmlesc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire run_item_t  item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);

  // run register: the input byte being expanded
  logic             run_busy_q;
  esc_kind_e        run_kind_q;
  logic [7:0]       run_raw_q;
  logic [IDX_W-1:0] run_idx_q;

  // result register
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;

  logic out_free;
  logic run_adv;
  logic run_end;
  logic in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign run_adv    = run_busy_q && out_free;
  assign run_end    = (run_idx_q == esc_last_idx(run_kind_q));
  assign in_stall_o = run_busy_q && !(run_adv && run_end);
  assign in_acc     = in_valid_i && !in_stall_o;

  // run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_busy_q <= 1'b0;
      run_idx_q  <= '0;
    end else if (in_acc) begin
      run_busy_q <= 1'b1;
      run_idx_q  <= '0;
    end else if (run_adv && run_end) begin
      run_busy_q <= 1'b0;
    end else if (run_adv) begin
      run_idx_q <= run_idx_q + IDX_W'(1);
    end
  end

  // run payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      run_kind_q <= item_i.kind;
      run_raw_q  <= item_i.raw;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (run_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (run_adv) begin
      out_byte_q <= esc_byte(run_kind_q, run_idx_q, run_raw_q);
      out_last_q <= run_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

endmodule

`default_nettype wire

[sv/xml_canonical_text_escaper.sv]
`default_nettype none

// channel   direction  handshake                  payload
// in        sink       in_valid_i / in_stall_o    in_byte_i
// out       source     out_valid_o / out_stall_i  out_byte_o, run_last_o
// cfg       apb slave  psel, penable, pwrite      paddr, pwdata, prdata
//
// a plain byte is one transfer per cycle while the output does not stall; an escape
// run stalls the input until its last byte moves to the result register
// an input byte passes through the run register and then the result register
// the run register and the result register set this rate; a new byte enters as the
// last byte of the previous run moves to the result register
// reset clears the mode to attribute and empties both registers
// a stalled output holds its byte while the run register waits behind it

module xml_canonical_text_escaper
  import xmlesc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         in_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [7:0]         out_byte_o,
  output logic                    run_last_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [MODE_W-1:0] norm_mode;
  run_item_t         item;

  // configuration registers
  xmlesc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .norm_mode_o (norm_mode)
  );

  // escape decision on the incoming byte
  xmlesc_classify u_classify (
    .byte_i      (in_byte_i),
    .norm_mode_i (norm_mode),
    .item_o      (item)
  );

  // run expansion and result register
  xmlesc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire
